// ----- design/rdc_pkg.sv -----
package rdc_pkg;

   localparam int VALUE_BITS  = 32;
   localparam int RADIX_W     = 6;
   localparam int CHAR_W      = 7;
   localparam int STORE_DEPTH = VALUE_BITS;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int COUNT_W     = $clog2(STORE_DEPTH + 1);
   localparam int ITER_W      = $clog2(VALUE_BITS);
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
   localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
   localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);

   localparam logic [CSR_ADDR_W-3:0] REG_RADIX = '0;

   localparam logic [CHAR_W-1:0] CHAR_ZERO   = CHAR_W'(48);
   localparam logic [CHAR_W-1:0] CHAR_LETTER = CHAR_W'(55);

   typedef struct packed {
      logic                  go;
      logic [VALUE_BITS-1:0] dividend;
      logic [RADIX_W-1:0]    divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [VALUE_BITS-1:0] quotient;
      logic [RADIX_W-1:0]    remainder;
   } div_rsp_type;

   function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] v);
      logic [RADIX_W-1:0] r;
      if (v < RADIX_MIN) begin
         r = RADIX_MIN;
      end else if (v > RADIX_MAX) begin
         r = RADIX_MAX;
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [CHAR_W-1:0] glyph(input logic [RADIX_W-1:0] d);
      logic [CHAR_W-1:0] c;
      if (d < RADIX_W'(10)) begin
         c = CHAR_ZERO + CHAR_W'(d);
      end else begin
         c = CHAR_LETTER + CHAR_W'(d);
      end
      return c;
   endfunction

endpackage

// ----- design/rdc_divider.sv -----
module rdc_divider
   import rdc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [ITER_W-1:0]     iter_ff, iter_in;
   logic [VALUE_BITS-1:0] quo_ff, quo_in;
   logic [RADIX_W-1:0]    rem_ff, rem_in;
   logic [RADIX_W-1:0]    div_ff, div_in;

   logic [RADIX_W:0]      rem_sh;
   logic [RADIX_W:0]      rem_sub;
   logic                  ge;

   assign rem_sh  = {rem_ff, quo_ff[VALUE_BITS-1]};
   assign ge      = rem_sh >= {1'b0, div_ff};
   assign rem_sub = rem_sh - {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      iter_in = iter_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (busy_ff) begin
         quo_in  = {quo_ff[VALUE_BITS-2:0], ge};
         rem_in  = ge ? rem_sub[RADIX_W-1:0] : rem_sh[RADIX_W-1:0];
         iter_in = iter_ff + ITER_W'(1);
         if (iter_ff == ITER_W'(VALUE_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (req.go) begin
         busy_in = 1'b1;
         iter_in = '0;
         quo_in  = req.dividend;
         rem_in  = '0;
         div_in  = req.divisor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         iter_ff <= iter_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

endmodule

// ----- design/rdc_digit_store.sv -----
module rdc_digit_store
   import rdc_pkg::*;
(
   input  logic               clock,
   input  logic               wr_en,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  logic [RADIX_W-1:0] wr_data,
   input  logic               rd_en,
   input  logic [ADDR_W-1:0]  rd_addr,
   output logic [RADIX_W-1:0] rd_data
);

   logic [RADIX_W-1:0] mem [STORE_DEPTH];
   logic [RADIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/radix_digit_converter.sv -----
// An item of D digits (D = digit count, 1 to 32) is worked one digit at a time:
// each digit is a remainder from the shared bit-serial divider, one quotient bit a cycle,
// and is written to the digit store; once all divisions are done, the digits are read back
// from the store, most significant first, through the READ and EMIT states and driven out.
// busy stays high until the last digit is driven out; the next item is taken once busy falls.
// Results are strobed for one cycle each on rsp_valid; the receiver cannot stall.
// Synchronous reset: radix returns to 10, digit count to 0, the store is left as is.
module radix_digit_converter
   import rdc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [VALUE_BITS-1:0] req_value,
   output logic                  rsp_valid,
   output logic [CHAR_W-1:0]     rsp_digit_char,
   output logic                  rsp_last_digit,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_GO   = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_READ = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [RADIX_W-1:0]    radix_ff, radix_in;
   logic [VALUE_BITS-1:0] num_ff, num_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [ADDR_W-1:0]     pos_ff, pos_in;
   logic                  valid_ff, valid_in;
   logic [CHAR_W-1:0]     char_ff, char_in;
   logic                  last_ff, last_in;

   div_req_type           div_req;
   div_rsp_type           div_rsp;
   logic                  wr_en;
   logic                  rd_en;
   logic [RADIX_W-1:0]    rd_data;
   logic                  csr_wr;
   logic                  accept;

   assign pready = 1'b1;
   assign prdata = CSR_DATA_W'(radix_ff);
   assign csr_wr = psel && penable && pwrite && pready
                   && (paddr[CSR_ADDR_W-1:2] == REG_RADIX);
   assign busy   = state_ff != ST_IDLE;
   assign accept = start && !busy;

   assign div_req.go       = state_ff == ST_GO;
   assign div_req.dividend = num_ff;
   assign div_req.divisor  = radix_ff;

   assign wr_en = (state_ff == ST_DIV) && div_rsp.done;
   assign rd_en = state_ff == ST_READ;

   always_comb begin
      radix_in = radix_ff;
      if (csr_wr) begin
         radix_in = clamp_radix(pwdata[RADIX_W-1:0]);
      end
   end

   always_comb begin
      state_in = state_ff;
      num_in   = num_ff;
      count_in = count_ff;
      pos_in   = pos_ff;
      valid_in = 1'b0;
      char_in  = char_ff;
      last_in  = last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               num_in   = req_value;
               count_in = '0;
               state_in = ST_GO;
            end
         end
         ST_GO: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               num_in   = div_rsp.quotient;
               count_in = count_ff + COUNT_W'(1);
               if ((div_rsp.quotient != '0)
                   && (count_ff[ADDR_W-1:0] != ADDR_W'(STORE_DEPTH - 1))) begin
                  state_in = ST_GO;
               end else begin
                  pos_in   = count_ff[ADDR_W-1:0];
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            valid_in = 1'b1;
            char_in  = glyph(rd_data);
            last_in  = pos_ff == '0;
            if (pos_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               pos_in   = pos_ff - ADDR_W'(1);
               state_in = ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         radix_ff <= RADIX_RESET;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         radix_ff <= radix_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
      num_ff  <= num_in;
      pos_ff  <= pos_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   rdc_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   rdc_digit_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (div_rsp.remainder),
      .rd_en   (rd_en),
      .rd_addr (pos_ff),
      .rd_data (rd_data)
   );

   assign rsp_valid      = valid_ff;
   assign rsp_digit_char = char_ff;
   assign rsp_last_digit = last_ff;

   a_valid_from_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_EMIT))
      else $error("digit strobed without an emit step");

   a_last_ends_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_digit |=> !rsp_valid)
      else $error("digit strobed after the final digit");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(STORE_DEPTH))
      else $error("digit count beyond store depth");

   a_accept_starts_div: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_GO)
      else $error("accepted item did not start a division");

endmodule
